>>> design/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds sizes, status codes and the word types shared by all modules.
package ffea_pkg;

    localparam int MaxExtents = 16;
    localparam int OffsetBits = 16;
    localparam int SizeBits   = OffsetBits + 1;
    localparam int IdxBits    = $clog2(MaxExtents);
    localparam int CntBits    = $clog2(MaxExtents + 1);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [16:0] request_size;
        logic [15:0] free_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
        logic [16:0] free_total;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word, reset scan
        logic step;      // examine entry at scan index, advance
        logic shift;     // one move step of insert or remove
        logic commit;    // final write, update count and free total
        logic finish;    // build result word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // scan has found a hit or run out of entries, or load rejected the word
        logic shift_done; // all moves done
    } t_sts;

endpackage

>>> design/ffea_datapath.sv
// Datapath of the first-fit extent allocator: extent table, scan and shift logic.
// Depends on ffea_pkg.
module ffea_datapath import ffea_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SizeBits-1:0] i_cfg_size,
    input  t_in_word            i_word,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output t_out_word           o_result
);

    localparam logic [SizeBits-1:0] RegionMax = SizeBits'(1) << OffsetBits;

    logic [OffsetBits-1:0] r_start [MaxExtents];
    logic [SizeBits-1:0]   r_len   [MaxExtents];
    logic [CntBits-1:0]    r_count;
    logic [SizeBits-1:0]   r_free;
    logic [SizeBits-1:0]   r_msize;

    logic                  r_op;
    logic [SizeBits-1:0]   r_size;
    logic [OffsetBits-1:0] r_where;
    logic [CntBits-1:0]    r_idx;
    logic [SizeBits:0]     r_prev_end;
    logic                  r_hit;
    logic                  r_done;
    logic [1:0]            r_status;
    logic [CntBits-1:0]    r_mv;
    logic [SizeBits-1:0]   r_flen;
    t_out_word             r_result;

    logic [IdxBits-1:0]    idx;
    logic [IdxBits-1:0]    mv;
    logic [SizeBits:0]     ent_start;
    logic [SizeBits:0]     ent_end;
    logic [SizeBits:0]     gap;
    logic [SizeBits:0]     tail;
    logic [SizeBits-1:0]   cfg_sat;
    logic [SizeBits-1:0]   n_free_add;
    logic                  at_end;

    assign idx       = r_idx[IdxBits-1:0];
    assign mv        = r_mv[IdxBits-1:0];
    assign at_end    = (r_idx == r_count);
    assign ent_start = (SizeBits+1)'(r_start[idx]);
    assign ent_end   = ent_start + (SizeBits+1)'(r_len[idx]);
    assign gap       = (ent_start > r_prev_end) ? ent_start - r_prev_end : '0;
    assign tail      = ((SizeBits+1)'(r_msize) > r_prev_end)
                       ? (SizeBits+1)'(r_msize) - r_prev_end : '0;
    assign cfg_sat   = (i_cfg_size == '0) ? SizeBits'(1)
                       : (i_cfg_size > RegionMax) ? RegionMax : i_cfg_size;
    assign n_free_add = ((SizeBits+1)'(r_free) + (SizeBits+1)'(r_flen)
                         > (SizeBits+1)'(r_msize))
                        ? r_msize : r_free + r_flen;

    assign o_sts.scan_done  = r_done;
    assign o_sts.shift_done = (r_op == OP_ALLOC) ? (r_mv <= r_idx)
                              : (r_mv + CntBits'(1) >= r_count);
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_msize <= RegionMax;
            r_free  <= RegionMax;
            r_done  <= 1'b0;
        end else if (i_cfg_we) begin
            r_count <= '0;
            r_msize <= cfg_sat;
            r_free  <= cfg_sat;
        end else if (i_cmd.load) begin
            r_op       <= i_word.opcode;
            r_size     <= i_word.request_size;
            r_where    <= i_word.free_offset;
            r_idx      <= '0;
            r_prev_end <= '0;
            r_hit      <= 1'b0;
            r_done     <= 1'b0;
            r_status   <= ST_OK;
            r_mv       <= '0;
            if (i_word.opcode == OP_ALLOC && i_word.request_size == '0) begin
                r_status <= ST_NO_SPACE;
                r_done   <= 1'b1;
            end else if (i_word.opcode == OP_ALLOC && r_count == CntBits'(MaxExtents)) begin
                r_status <= ST_TABLE_FULL;
                r_done   <= 1'b1;
            end
        end else if (i_cmd.step) begin
            if (at_end) begin
                r_done <= 1'b1;
                if (r_op == OP_ALLOC) begin
                    r_status <= (tail < (SizeBits+1)'(r_size)) ? ST_NO_SPACE : ST_OK;
                    r_hit    <= !(tail < (SizeBits+1)'(r_size));
                end else begin
                    r_status <= ST_NOT_FOUND;
                end
                r_mv <= r_count;
            end else if (r_op == OP_ALLOC) begin
                if (gap >= (SizeBits+1)'(r_size)) begin
                    r_done <= 1'b1;
                    r_hit  <= 1'b1;
                    r_mv   <= r_count;
                end else begin
                    r_prev_end <= ent_end;
                    r_idx      <= r_idx + CntBits'(1);
                end
            end else begin
                if (r_start[idx] == r_where) begin
                    r_done <= 1'b1;
                    r_hit  <= 1'b1;
                    r_flen <= r_len[idx];
                    r_mv   <= r_idx;
                end else begin
                    r_idx <= r_idx + CntBits'(1);
                end
            end
        end else if (i_cmd.shift) begin
            if (r_op == OP_ALLOC) begin
                r_start[mv] <= r_start[mv - IdxBits'(1)];
                r_len[mv]   <= r_len[mv - IdxBits'(1)];
                r_mv        <= r_mv - CntBits'(1);
            end else begin
                r_start[mv] <= r_start[mv + IdxBits'(1)];
                r_len[mv]   <= r_len[mv + IdxBits'(1)];
                r_mv        <= r_mv + CntBits'(1);
            end
        end else if (i_cmd.commit) begin
            if (r_hit) begin
                if (r_op == OP_ALLOC) begin
                    r_start[idx] <= r_prev_end[OffsetBits-1:0];
                    r_len[idx]   <= r_size;
                    r_count      <= r_count + CntBits'(1);
                    r_free       <= (r_free >= r_size) ? r_free - r_size : '0;
                end else begin
                    r_count <= r_count - CntBits'(1);
                    r_free  <= n_free_add;
                end
            end
        end else if (i_cmd.finish) begin
            r_done <= 1'b0;
        end
    end

    // Result word, built once the table update has settled.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.status     <= r_status;
            r_result.free_total <= r_free;
            if (r_status != ST_OK) begin
                r_result.offset <= '0;
            end else if (r_op == OP_ALLOC) begin
                r_result.offset <= r_prev_end[OffsetBits-1:0];
            end else begin
                r_result.offset <= r_where;
            end
        end
    end

endmodule

>>> design/ffea_ctrl.sv
// Controller state machine of the first-fit extent allocator.
// Depends on ffea_pkg; drives ffea_datapath through t_cmd.
module ffea_ctrl import ffea_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_COMMIT = 6'b001000,
        S_FINISH = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // A new word may be taken as soon as the previous result sits in the
    // output register and is being taken.
    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator.
// Depends on ffea_pkg, ffea_ctrl and ffea_datapath.
//
// The block manages a region of memory_size bytes as a table of up to
// MaxExtents allocated extents, kept sorted by start offset. An input word
// either allocates (first gap in address order that fits) or frees (exact
// start offset match). Each input word yields exactly one result word with a
// status, the offset and the free byte total after the operation.
// Both channels use valid/ready. The configuration port writes memory_size
// whenever i_cfg_we is high; that also empties the table. Write it only when
// the block is idle.
// After the word is accepted, the controller passes through scan, the move of
// the table, commit and finish; the result then sits in the output register.
// The scan and the one-entry-per-cycle move of the table make the time to the
// result grow with the number of entries held. A zero-size or full-table
// allocate is rejected at load and does no scan step and no move.
// The result is held in an output register until taken; while the receiver
// stalls the block holds that word and accepts no new input. A new input word
// is taken in the same cycle the result is taken.
// Reset empties the table and sets memory_size and the free total to 65536.
module first_fit_extent_allocator import ffea_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SizeBits-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_data
);

    t_cmd cmd;
    t_sts sts;

    ffea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffea_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_size (i_cfg_wdata),
        .i_word     (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_out_data)
    );

    // An error result always carries offset zero.
    a_err_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.offset == '0))
        else $error("error result with nonzero offset");

    // Only one command is issued per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // A result appears only right after the finish command.
    a_out_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.finish))
        else $error("result valid without finish");

endmodule

>>> tb/ffea_checker.sv
// Checker for the first-fit extent allocator: watches both channels, predicts
// each result word and compares it field by field. Depends on ffea_pkg.
`timescale 1ns / 1ps
module ffea_checker import ffea_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SizeBits-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_word            i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_word           i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [SizeBits-1:0]   region_size;
    logic [OffsetBits-1:0] ext_base [MaxExtents];
    logic [SizeBits-1:0]   ext_len  [MaxExtents];
    int                    ext_used;
    logic [SizeBits-1:0]   free_bytes;
    t_out_word             expected_words[$];

    assign o_pending = expected_words.size();

    // Apply one input word to the shadow table and return the result word.
    function automatic t_out_word apply_word(t_in_word w);
        t_out_word r;
        logic [SizeBits:0] prev_end;
        logic [SizeBits:0] gap;
        int slot;
        bit hit;
        r = '0;
        if (w.opcode == OP_ALLOC) begin
            prev_end = '0;
            hit = 0;
            slot = ext_used;
            if (w.request_size == 0) begin
                r.status = ST_NO_SPACE;
            end else if (ext_used >= MaxExtents) begin
                r.status = ST_TABLE_FULL;
            end else begin
                for (int i = 0; i < ext_used && !hit; i++) begin
                    gap = (ext_base[i] > prev_end) ? ext_base[i] - prev_end : '0;
                    if (gap >= w.request_size) begin
                        slot = i;
                        hit = 1;
                    end else begin
                        prev_end = ext_base[i] + ext_len[i];
                    end
                end
                if (!hit) begin
                    gap = (region_size > prev_end) ? region_size - prev_end : '0;
                    if (gap >= w.request_size) hit = 1;
                end
                if (!hit) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    for (int i = ext_used; i > slot; i--) begin
                        ext_base[i] = ext_base[i-1];
                        ext_len[i]  = ext_len[i-1];
                    end
                    ext_base[slot] = prev_end[OffsetBits-1:0];
                    ext_len[slot]  = w.request_size;
                    ext_used++;
                    free_bytes = (free_bytes >= w.request_size) ?
                                 free_bytes - w.request_size : '0;
                    r.status = ST_OK;
                    r.offset = prev_end[OffsetBits-1:0];
                end
            end
        end else begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < ext_used; i++) begin
                if (r.status == ST_NOT_FOUND && ext_base[i] == w.free_offset) begin
                    free_bytes = (free_bytes + ext_len[i] > region_size) ?
                                 region_size : free_bytes + ext_len[i];
                    for (int k = i; k + 1 < ext_used; k++) begin
                        ext_base[k] = ext_base[k+1];
                        ext_len[k]  = ext_len[k+1];
                    end
                    ext_used--;
                    r.status = ST_OK;
                    r.offset = w.free_offset;
                end
            end
        end
        r.free_total = free_bytes;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            region_size = 17'd65536;
            free_bytes  = 17'd65536;
            ext_used    = 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                // A write saturates to the legal range and empties the table.
                region_size = (i_cfg_wdata == 0) ? 17'd1 :
                              (i_cfg_wdata > 17'd65536) ? 17'd65536 : i_cfg_wdata;
                free_bytes = region_size;
                ext_used = 0;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.status != i_out_data.status ||
                        want.offset != i_out_data.offset ||
                        want.free_total != i_out_data.free_total) begin
                        $display("%0t: mismatch expected st=%0d off=%0d free=%0d,",
                                 $time, want.status, want.offset, want.free_total,
                                 " actual st=%0d off=%0d free=%0d",
                                 i_out_data.status, i_out_data.offset,
                                 i_out_data.free_total);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_words.push_back(apply_word(i_in_data));
        end
    end

endmodule

>>> tb/first_fit_extent_allocator_tb.sv
// Testbench top for the first-fit extent allocator: drives the words and the
// size register and gives the verdict. Depends on ffea_pkg, ffea_checker and first_fit_extent_allocator.
`timescale 1ns / 1ps
module first_fit_extent_allocator_tb;
    import ffea_pkg::*;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                cfg_we = 0;
    logic [SizeBits-1:0] cfg_wdata = '0;
    logic                in_valid = 0;
    logic                in_ready;
    t_in_word            in_word = '0;
    logic                out_valid;
    logic                out_ready = 0;
    t_out_word           out_word;
    int                  fail_count;
    int                  pending;
    bit                  long_hold = 0;

    // Offsets handed out so far; frees mostly pick from this list.
    logic [OffsetBits-1:0] live_offsets[$];
    logic                  sent_ops[$];
    logic [SizeBits-1:0]   cur_size = 17'd65536;

    always #6 i_clk = ~i_clk;

    first_fit_extent_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_word)
    );

    ffea_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Offer one word and hold it until the block takes it. Valid stays high
    // after acceptance so that a word with no gap follows back to back.
    task automatic send_word(input logic op, input logic [16:0] sz,
                             input logic [15:0] where, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{opcode: op, request_size: sz, free_offset: where};
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_alloc(input logic [16:0] sz, input int gap);
        send_word(OP_ALLOC, sz, 16'($urandom), gap);
    endtask

    task automatic send_free(input logic [15:0] where, input int gap);
        send_word(OP_FREE, 17'($urandom), where, gap);
    endtask

    // Wait for every expected word, let the block settle, then write the size.
    task automatic write_size(input logic [16:0] value);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_size = (value == 0) ? 17'd1 : (value > 17'd65536) ? 17'd65536 : value;
        live_offsets.delete();
    endtask

    // The receiver stalls at random, and once for a long stretch so that the
    // block fills up and stops taking input words.
    always @(posedge i_clk) begin
        int wait_left;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            wait_left = 0;
        end else if (long_hold) begin
            out_ready <= 1'b0;
        end else if (wait_left > 0) begin
            wait_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (out_valid && out_ready) wait_left = $urandom_range(0, 13);
        end
    end

    // Track the block's grants so later frees hit live extents.
    always @(posedge i_clk) begin
        logic op;
        if (i_rst_n) begin
            if (out_valid && out_ready && sent_ops.size() != 0) begin
                op = sent_ops.pop_front();
                if (op == OP_ALLOC && out_word.status == ST_OK)
                    live_offsets.push_back(out_word.offset);
            end
            if (in_valid && in_ready) sent_ops.push_back(in_word.opcode);
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int gap;
        int no_idle;
        logic [16:0] sz;
        logic [15:0] where;
        int pick;
        int sel;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: extremes, zero size, oversize, unknown free, full table.
        send_alloc(17'd0, 0);
        send_alloc(17'd65537, 0);
        send_alloc(17'h1FFFF, 0);
        send_alloc(17'd65536, 0);
        send_free(16'd0, 0);
        send_free(16'hFFFF, 0);
        send_alloc(17'd1, 0);
        write_size(17'd0);
        send_alloc(17'd1, 0);
        send_alloc(17'd1, 0);
        send_free(16'd0, 0);
        write_size(17'h1FFFF);
        for (int i = 0; i < 17; i++) send_alloc(17'd16, 1);
        send_free(16'd0, 0);
        send_alloc(17'd8, 0);
        send_alloc(17'd8, 0);
        send_free(16'd240, 0);
        write_size(17'd300);

        // Random phases at several region sizes.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_size(17'd100);
                1: write_size(17'd1);
                2: write_size(17'($urandom_range(2, 65536)));
                3: write_size(17'd65536);
                4: write_size(17'($urandom));
                5: write_size(17'd1000);
                6: write_size(17'd70000);
                default: write_size(17'($urandom_range(16, 4096)));
            endcase
            live_offsets.delete();
            for (int n = 0; n < 125; n++) begin
                no_idle = (phase == 3);
                gap = no_idle ? 0 : $urandom_range(0, 13);
                if (phase == 2 && n == 40) begin
                    long_hold = 1'b1;
                    fork
                        begin repeat (300) @(posedge i_clk); long_hold = 1'b0; end
                    join_none
                end
                if (phase == 5 && n == 60) begin
                    // Hold the sender until the block has drained.
                    in_valid <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    if ($urandom_range(0, 9) == 0) sz = 17'($urandom);
                    else sz = 17'($urandom_range(1, (cur_size >> 3) + 1));
                    send_alloc(sz, gap);
                end else if (pick < 90 && live_offsets.size() != 0) begin
                    sel = $urandom_range(0, live_offsets.size() - 1);
                    where = live_offsets[sel];
                    live_offsets.delete(sel);
                    send_free(where, gap);
                end else begin
                    send_free(16'($urandom), gap);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> first_fit_extent_allocator.f
design/ffea_pkg.sv
design/ffea_datapath.sv
design/ffea_ctrl.sv
design/first_fit_extent_allocator.sv
tb/ffea_checker.sv
tb/first_fit_extent_allocator_tb.sv
